[hw/rtl/sfc_pkg.sv]
`default_nettype none

package sfc_pkg;

    // Plane set and register port
    localparam int NUM_PLANES = 6;
    localparam int CFG_W      = 64;
    localparam int CFG_IDX_W  = 3;

    // Field widths
    localparam int COORD_W = 24;   // signed Q16.8 center
    localparam int HALF_W  = 23;   // unsigned Q15.8 half-extent
    localparam int NORM_W  = 13;   // signed Q2.11 normal component
    localparam int OFF_W   = 25;   // signed Q17.8 plane offset
    localparam int OFF_SH  = 11;   // offset scaled to the Q.19 distance

    // Stream packing
    localparam int IN_TDATA_W  = 144;
    localparam int OUT_TDATA_W = 8;
    localparam int CX_LSB = 0;
    localparam int CY_LSB = CX_LSB + COORD_W;
    localparam int CZ_LSB = CY_LSB + COORD_W;
    localparam int HX_LSB = CZ_LSB + COORD_W;
    localparam int HY_LSB = HX_LSB + HALF_W;
    localparam int HZ_LSB = HY_LSB + HALF_W;

    // Plane register layout
    localparam int NX_LSB  = 0;
    localparam int NY_LSB  = NX_LSB + NORM_W;
    localparam int NZ_LSB  = NY_LSB + NORM_W;
    localparam int OFF_LSB = NZ_LSB + NORM_W;

    // Datapath widths
    localparam int PROD_W   = NORM_W + COORD_W;   // n * c
    localparam int OFFS_W   = OFF_W + OFF_SH;     // offset in Q.19
    localparam int DIST_W   = 40;                 // |D| <= 2^37, signed
    localparam int MAG_W    = 38;
    localparam int SPLIT_W  = MAG_W / 2;
    localparam int PP_W     = 2 * SPLIT_W;
    localparam int SQ_W     = 2 * HALF_W;
    localparam int RAD_W    = SQ_W + 2;           // sum of three squares
    localparam int RAD_SH   = 22;                 // S * 2^22 vs D^2
    localparam int CMP_W    = 2 * MAG_W;

    // Pipeline stages
    localparam int NUM_STAGES = 5;
    localparam int ST_MUL = 0;   // products and squares
    localparam int ST_SUM = 1;   // plane distance, squared radius
    localparam int ST_ABS = 2;   // sign and magnitude of distance
    localparam int ST_PP  = 3;   // partial products of distance squared
    localparam int ST_OUT = 4;   // visible flag, output register

    typedef struct packed {
        logic [NUM_STAGES-1:0] en;
    } sfc_adv_t;

endpackage

`default_nettype wire

[hw/rtl/sfc_rad.sv]
`default_nettype none

module sfc_rad
    import sfc_pkg::*;
(
    input  wire logic              clk,
    input  wire sfc_adv_t          adv,
    input  wire logic [HALF_W-1:0] half_x,
    input  wire logic [HALF_W-1:0] half_y,
    input  wire logic [HALF_W-1:0] half_z,
    output logic      [RAD_W-1:0]  sq_rad
);

    logic [SQ_W-1:0]  sqx_reg;
    logic [SQ_W-1:0]  sqy_reg;
    logic [SQ_W-1:0]  sqz_reg;
    logic [RAD_W-1:0] sum_reg;
    logic [RAD_W-1:0] abs_reg;
    logic [RAD_W-1:0] pp_reg;
    logic [RAD_W-1:0] sum_next;

    assign sum_next = RAD_W'(sqx_reg) + RAD_W'(sqy_reg) + RAD_W'(sqz_reg);

    always_ff @(posedge clk)
    begin
        if (adv.en[ST_MUL])
        begin
            sqx_reg <= SQ_W'(half_x * half_x);
            sqy_reg <= SQ_W'(half_y * half_y);
            sqz_reg <= SQ_W'(half_z * half_z);
        end
        if (adv.en[ST_SUM])
        begin
            sum_reg <= sum_next;
        end
        // carry the squared radius alongside the distance stages
        if (adv.en[ST_ABS])
        begin
            abs_reg <= sum_reg;
        end
        if (adv.en[ST_PP])
        begin
            pp_reg <= abs_reg;
        end
    end

    assign sq_rad = pp_reg;

endmodule

`default_nettype wire

[hw/rtl/sfc_dist.sv]
`default_nettype none

module sfc_dist
    import sfc_pkg::*;
(
    input  wire logic                     clk,
    input  wire sfc_adv_t                 adv,
    input  wire logic [CFG_W-1:0]         plane,
    input  wire logic signed [COORD_W-1:0] center_x,
    input  wire logic signed [COORD_W-1:0] center_y,
    input  wire logic signed [COORD_W-1:0] center_z,
    output logic                          neg,
    output logic [MAG_W-1:0]              mag
);

    logic signed [NORM_W-1:0] nx;
    logic signed [NORM_W-1:0] ny;
    logic signed [NORM_W-1:0] nz;
    logic signed [OFF_W-1:0]  off;

    logic signed [PROD_W-1:0] px_reg;
    logic signed [PROD_W-1:0] py_reg;
    logic signed [PROD_W-1:0] pz_reg;
    logic signed [OFF_W-1:0]  off_reg;
    logic signed [OFFS_W-1:0] off_sh;
    logic signed [DIST_W-1:0] dist_next;
    logic signed [DIST_W-1:0] dist_reg;
    logic signed [DIST_W-1:0] dist_neg;
    logic                     neg_reg;
    logic [MAG_W-1:0]         mag_reg;

    assign nx  = plane[NX_LSB +: NORM_W];
    assign ny  = plane[NY_LSB +: NORM_W];
    assign nz  = plane[NZ_LSB +: NORM_W];
    assign off = plane[OFF_LSB +: OFF_W];

    assign off_sh    = {off_reg, {OFF_SH{1'b0}}};
    assign dist_next = DIST_W'(px_reg) + DIST_W'(py_reg) + DIST_W'(pz_reg)
                     - DIST_W'(off_sh);
    assign dist_neg  = -dist_reg;

    always_ff @(posedge clk)
    begin
        if (adv.en[ST_MUL])
        begin
            px_reg  <= PROD_W'(nx * center_x);
            py_reg  <= PROD_W'(ny * center_y);
            pz_reg  <= PROD_W'(nz * center_z);
            off_reg <= off;
        end
        if (adv.en[ST_SUM])
        begin
            dist_reg <= dist_next;
        end
        // magnitude only matters when the distance is negative
        if (adv.en[ST_ABS])
        begin
            neg_reg <= dist_reg[DIST_W-1];
            mag_reg <= dist_neg[MAG_W-1:0];
        end
    end

    assign neg = neg_reg;
    assign mag = mag_reg;

endmodule

`default_nettype wire

[hw/rtl/sfc_cmp.sv]
`default_nettype none

module sfc_cmp
    import sfc_pkg::*;
(
    input  wire logic             clk,
    input  wire sfc_adv_t         adv,
    input  wire logic             neg,
    input  wire logic [MAG_W-1:0] mag,
    input  wire logic [RAD_W-1:0] sq_rad,
    output logic                  outside
);

    logic [SPLIT_W-1:0] mh;
    logic [SPLIT_W-1:0] ml;
    logic [PP_W-1:0]    hh_reg;
    logic [PP_W-1:0]    hl_reg;
    logic [PP_W-1:0]    ll_reg;
    logic               neg_reg;
    logic [CMP_W-1:0]   dsq;
    logic [CMP_W-1:0]   rhs;

    assign mh = mag[MAG_W-1:SPLIT_W];
    assign ml = mag[SPLIT_W-1:0];

    always_ff @(posedge clk)
    begin
        if (adv.en[ST_PP])
        begin
            hh_reg  <= PP_W'(mh * mh);
            hl_reg  <= PP_W'(mh * ml);
            ll_reg  <= PP_W'(ml * ml);
            neg_reg <= neg;
        end
    end

    // D^2 = hh*2^38 + 2*hl*2^19 + ll, against S*2^22
    assign dsq = (CMP_W'(hh_reg) << (2 * SPLIT_W))
               + (CMP_W'(hl_reg) << (SPLIT_W + 1))
               + CMP_W'(ll_reg);
    assign rhs = CMP_W'(sq_rad) << RAD_SH;

    assign outside = neg_reg && (dsq > rhs);

endmodule

`default_nettype wire

[hw/rtl/sphere_frustum_cull_core.sv]
// Bounding-sphere frustum cull. Each request on the slave stream carries a
// sphere center and three half-extents; the radius is the length of the
// half-extent vector. The six planes (near, far, left, right, top, bottom)
// are to be written through the register port at indexes 0 to 5 while the
// block is idle, typically once per frame; the block does not enforce this.
// After reset every plane is zero and culls nothing. One request is taken
// every clock cycle; back-pressure on the master side stalls the stages in
// order, filling bubbles first. A request passes through one stage of 13x24
// plane products and radius squares, one summing the plane distance, one
// taking its magnitude, one of 19x19 partial products of the distance
// squared, and the output register holding the visible flag.
`default_nettype none

module sphere_frustum_cull_core
    import sfc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_W-1:0]       cfg_data,

    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // center_x[23:0], center_y[47:24], center_z[71:48], half_x[94:72],
    // half_y[117:95], half_z[140:118], zero pad [143:141]
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,

    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // visible[0], zero pad [7:1]
    output logic [OUT_TDATA_W-1:0]      m_tdata
);

    logic [CFG_W-1:0]          plane_reg [NUM_PLANES];
    logic [NUM_STAGES-1:0]     vld_reg;
    logic [NUM_STAGES-1:0]     vld_next;
    sfc_adv_t                  adv;
    logic                      vis_reg;

    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic signed [COORD_W-1:0] center_z;
    logic [HALF_W-1:0]         half_x;
    logic [HALF_W-1:0]         half_y;
    logic [HALF_W-1:0]         half_z;
    logic [RAD_W-1:0]          sq_rad;
    logic [NUM_PLANES-1:0]     outside;

    assign center_x = s_tdata[CX_LSB +: COORD_W];
    assign center_y = s_tdata[CY_LSB +: COORD_W];
    assign center_z = s_tdata[CZ_LSB +: COORD_W];
    assign half_x   = s_tdata[HX_LSB +: HALF_W];
    assign half_y   = s_tdata[HY_LSB +: HALF_W];
    assign half_z   = s_tdata[HZ_LSB +: HALF_W];

    // Plane registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_PLANES; i++)
            begin
                plane_reg[i] <= '0;
            end
        end
        else if (cfg_wr_en && (cfg_index < CFG_IDX_W'(NUM_PLANES)))
        begin
            plane_reg[cfg_index] <= cfg_data;
        end
    end

    // A stage advances when it is empty or the stage after it advances
    always_comb
    begin
        adv.en[ST_OUT] = !vld_reg[ST_OUT] || m_tready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            adv.en[k] = !vld_reg[k] || adv.en[k+1];
        end
    end

    always_comb
    begin
        for (int k = 0; k < NUM_STAGES; k++)
        begin
            if (!adv.en[k])
            begin
                vld_next[k] = vld_reg[k];
            end
            else if (k == ST_MUL)
            begin
                vld_next[k] = s_tvalid;
            end
            else
            begin
                vld_next[k] = vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    sfc_rad u_rad (
        .clk    (clk),
        .adv    (adv),
        .half_x (half_x),
        .half_y (half_y),
        .half_z (half_z),
        .sq_rad (sq_rad)
    );

    for (genvar p = 0; p < NUM_PLANES; p++)
    begin : g_plane
        logic             neg;
        logic [MAG_W-1:0] mag;

        sfc_dist u_dist (
            .clk      (clk),
            .adv      (adv),
            .plane    (plane_reg[p]),
            .center_x (center_x),
            .center_y (center_y),
            .center_z (center_z),
            .neg      (neg),
            .mag      (mag)
        );

        sfc_cmp u_cmp (
            .clk     (clk),
            .adv     (adv),
            .neg     (neg),
            .mag     (mag),
            .sq_rad  (sq_rad),
            .outside (outside[p])
        );
    end

    always_ff @(posedge clk)
    begin
        if (adv.en[ST_OUT])
        begin
            vis_reg <= ~|outside;
        end
    end

    assign s_tready = adv.en[ST_MUL];
    assign m_tvalid = vld_reg[ST_OUT];
    assign m_tdata  = {{(OUT_TDATA_W-1){1'b0}}, vis_reg};

    // An open output means the whole pipe moves and a request can be taken
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tready || !m_tvalid) |-> s_tready)
        else $error("input stalled although the output can drain");

    // A stalled stage keeps its item
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[ST_PP] && !adv.en[ST_PP]) |=> vld_reg[ST_PP])
        else $error("item lost in a stalled stage");

    // An advancing stage takes the item from the stage before it
    a_item_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (adv.en[ST_SUM] && vld_reg[ST_MUL]) |=> vld_reg[ST_SUM])
        else $error("item dropped between stages");

    // An accepted request enters the first stage
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> vld_reg[ST_MUL])
        else $error("accepted request did not enter the pipe");

endmodule

`default_nettype wire
